// ----- rtl/dpdt_pkg.sv -----
// Shared types and constants for the delayed priority dispatch table.
package dpdt_pkg;

  localparam logic [1:0] KIND_ADD      = 2'd0;
  localparam logic [1:0] KIND_DISPATCH = 2'd1;
  localparam logic [1:0] KIND_EMPTY    = 2'd2;

  localparam logic [2:0] PRIO_LOW  = 3'd1;
  localparam logic [2:0] PRIO_HIGH = 3'd4;

  localparam logic OP_ADD    = 1'b0;
  localparam logic OP_UPDATE = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SNAP,
    ST_SCAN,
    ST_EMIT
  } state_e;

  // Control broadcast to every cell.
  typedef struct packed {
    logic add_en;
    logic snap;
    logic clr;
  } cell_ctrl_t;

  // Best candidate handed from cell to cell during a scan.
  typedef struct packed {
    logic        found;
    logic        more;
    logic [2:0]  prio;
    logic [31:0] seq;
    logic [15:0] handle;
  } wave_t;

endpackage

// ----- rtl/delayed_priority_dispatch_table.sv -----
// Top level: control sequencer and the row of slot cells.
// An add's status appears on the result ports in the next cycle, with busy
// staying low. An update first samples readiness in all slots, then runs one
// scan per dispatched task: a candidate ripples through the row of TABLE_SLOTS
// cells, one cell per cycle, and the winner is then freed and reported. An
// update dispatches at most DISPATCH_LIMIT tasks and holds busy until it is
// done. Each result is shown for a single cycle under result_strobe_o and must
// be taken then.
module delayed_priority_dispatch_table import dpdt_pkg::*; #(
  parameter int TABLE_SLOTS    = 8,
  parameter int DISPATCH_LIMIT = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start,
  output logic        busy,
  input  logic        operation_i,
  input  logic [15:0] task_handle_i,
  input  logic [28:0] delay_ms_i,
  input  logic [2:0]  task_priority_i,
  input  logic [31:0] current_tick_i,
  output logic        result_strobe_o,
  output logic [1:0]  result_kind_o,
  output logic        accepted_o,
  output logic [15:0] dispatched_handle_o,
  output logic        last_o
);

  localparam int IW = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int KW = $clog2(DISPATCH_LIMIT + 1);

  state_e state_q, state_d;
  logic [31:0] seq_q, seq_d, now_q, tick_w;
  logic [IW-1:0] scan_q, scan_d;
  logic [KW-1:0] count_q, count_d;
  logic        strobe_d, strobe_q, acc_d, acc_q, last_d, last_q;
  logic [1:0]  kind_d, kind_q;
  logic [15:0] hnd_d, hnd_q;
  logic        accept, add_valid, add_ok;
  logic [31:0] delay_ticks;
  cell_ctrl_t  ctrl;

  logic  free_c [TABLE_SLOTS];
  wave_t wave_c [TABLE_SLOTS];
  logic [IW-1:0] idx_c [TABLE_SLOTS];

  assign accept    = start && !busy;
  assign add_valid = accept && operation_i == OP_ADD && task_handle_i != 16'd0 &&
                     task_priority_i >= PRIO_LOW && task_priority_i <= PRIO_HIGH;
  assign add_ok    = add_valid && free_c[TABLE_SLOTS-1];
  // delay times ten, kept modulo 2^32.
  assign delay_ticks = {delay_ms_i, 3'b000} + {2'b00, delay_ms_i, 1'b0};
  assign tick_w      = (state_q == ST_SNAP) ? now_q : current_tick_i;

  for (genvar k = 0; k < TABLE_SLOTS; k++) begin : g_cell
    logic          f_in;
    wave_t         w_in;
    logic [IW-1:0] i_in;
    if (k == 0) begin : g_head
      assign f_in = 1'b0;
      assign w_in = '0;
      assign i_in = '0;
    end else begin : g_link
      assign f_in = free_c[k-1];
      assign w_in = wave_c[k-1];
      assign i_in = idx_c[k-1];
    end
    dpdt_cell #(.IW(IW), .IDX(k)) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctrl_i        (ctrl),
      .clr_idx_i     (idx_c[TABLE_SLOTS-1]),
      .handle_i      (task_handle_i),
      .delay_ticks_i (delay_ticks),
      .prio_i        (task_priority_i),
      .tick_i        (tick_w),
      .seq_i         (seq_q),
      .free_i        (f_in),
      .free_o        (free_c[k]),
      .wave_i        (w_in),
      .idx_i         (i_in),
      .wave_o        (wave_c[k]),
      .idx_o         (idx_c[k])
    );
  end

  always_comb begin
    state_d  = state_q;
    seq_d    = seq_q;
    scan_d   = scan_q;
    count_d  = count_q;
    strobe_d = 1'b0;
    kind_d   = kind_q;
    acc_d    = 1'b0;
    hnd_d    = 16'd0;
    last_d   = 1'b0;
    ctrl     = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          if (operation_i == OP_ADD) begin
            ctrl.add_en = add_valid;
            strobe_d    = 1'b1;
            kind_d      = KIND_ADD;
            acc_d       = add_ok;
            last_d      = 1'b1;
            if (add_ok) begin
              seq_d = seq_q + 32'd1;
            end
          end else begin
            count_d = '0;
            state_d = ST_SNAP;
          end
        end
      end
      ST_SNAP: begin
        ctrl.snap = 1'b1;
        scan_d    = '0;
        state_d   = ST_SCAN;
      end
      ST_SCAN: begin
        scan_d = scan_q + IW'(1);
        if (scan_q == IW'(TABLE_SLOTS - 1)) begin
          state_d = ST_EMIT;
        end
      end
      ST_EMIT: begin
        strobe_d = 1'b1;
        scan_d   = '0;
        if (wave_c[TABLE_SLOTS-1].found) begin
          ctrl.clr = 1'b1;
          kind_d   = KIND_DISPATCH;
          hnd_d    = wave_c[TABLE_SLOTS-1].handle;
          count_d  = count_q + KW'(1);
          last_d   = !wave_c[TABLE_SLOTS-1].more ||
                     (count_q + KW'(1) == KW'(DISPATCH_LIMIT));
          state_d  = last_d ? ST_IDLE : ST_SCAN;
        end else begin
          kind_d  = KIND_EMPTY;
          last_d  = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      seq_q    <= 32'd0;
      scan_q   <= '0;
      count_q  <= '0;
      strobe_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      seq_q    <= seq_d;
      scan_q   <= scan_d;
      count_q  <= count_d;
      strobe_q <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      now_q <= current_tick_i;
    end
    kind_q <= kind_d;
    acc_q  <= acc_d;
    hnd_q  <= hnd_d;
    last_q <= last_d;
  end

  assign busy                = state_q != ST_IDLE;
  assign result_strobe_o     = strobe_q;
  assign result_kind_o       = kind_q;
  assign accepted_o          = acc_q;
  assign dispatched_handle_o = hnd_q;
  assign last_o              = last_q;

  a_dispatch_nonzero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_strobe_o && result_kind_o == KIND_DISPATCH |-> dispatched_handle_o != 16'd0)
    else $error("dispatched a task with a zero handle");

  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_EMIT |-> count_q < KW'(DISPATCH_LIMIT))
    else $error("dispatch count passed the limit");

  a_add_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy && operation_i == OP_ADD |=> result_strobe_o && last_o &&
    result_kind_o == KIND_ADD)
    else $error("add transfer gave no status in the next cycle");

endmodule

// ----- rtl/dpdt_cell.sv -----
// One table slot: stored task, free-slot chain and one stage of the dispatch scan.
module dpdt_cell import dpdt_pkg::*; #(
  parameter int IW  = 3,
  parameter int IDX = 0
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  cell_ctrl_t    ctrl_i,
  input  logic [IW-1:0] clr_idx_i,
  input  logic [15:0]   handle_i,
  input  logic [31:0]   delay_ticks_i,
  input  logic [2:0]    prio_i,
  input  logic [31:0]   tick_i,
  input  logic [31:0]   seq_i,
  input  logic          free_i,
  output logic          free_o,
  input  wave_t         wave_i,
  input  logic [IW-1:0] idx_i,
  output wave_t         wave_o,
  output logic [IW-1:0] idx_o
);

  logic        used_q, elig_q;
  logic [15:0] handle_q;
  logic [31:0] start_q, delay_q, seq_q;
  logic [2:0]  prio_q;
  logic        take, better;
  wave_t       wave_d, wave_q;
  logic [IW-1:0] idx_d, idx_q;

  assign free_o = free_i | ~used_q;
  assign take   = ctrl_i.add_en & ~free_i & ~used_q;

  // Strictly better only, so the lowest slot wins a tie.
  assign better = elig_q & (~wave_i.found | (prio_q > wave_i.prio) |
                  ((prio_q == wave_i.prio) & (seq_q < wave_i.seq)));

  always_comb begin
    wave_d       = wave_i;
    idx_d        = idx_i;
    wave_d.found = wave_i.found | elig_q;
    wave_d.more  = wave_i.more | (wave_i.found & elig_q);
    if (better) begin
      wave_d.prio   = prio_q;
      wave_d.seq    = seq_q;
      wave_d.handle = handle_q;
      idx_d         = IW'(IDX);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_q <= 1'b0;
      elig_q <= 1'b0;
    end else begin
      if (take) begin
        used_q <= 1'b1;
      end else if (ctrl_i.clr && clr_idx_i == IW'(IDX)) begin
        used_q <= 1'b0;
      end
      if (ctrl_i.snap) begin
        elig_q <= used_q & (seq_q < seq_i) & ((tick_i - start_q) >= delay_q);
      end else if (ctrl_i.clr && clr_idx_i == IW'(IDX)) begin
        elig_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      handle_q <= handle_i;
      start_q  <= tick_i;
      delay_q  <= delay_ticks_i;
      seq_q    <= seq_i;
      prio_q   <= prio_i;
    end
    wave_q <= wave_d;
    idx_q  <= idx_d;
  end

  assign wave_o = wave_q;
  assign idx_o  = idx_q;

endmodule

// ----- sim/testbench.sv -----
// Self-checking testbench for the delayed priority dispatch table.
`timescale 1ns / 1ps

class dispatch_scoreboard;
  typedef struct {
    logic [1:0]  kind;
    logic        acc;
    logic [15:0] handle;
    logic        last;
  } dispatch_result_t;

  localparam int SLOTS = 8;
  localparam int LIMIT = 4;

  bit          used [SLOTS];
  logic [15:0] handle_q [SLOTS];
  logic [31:0] start_q [SLOTS];
  logic [31:0] delay_q [SLOTS];
  logic [31:0] seq_q [SLOTS];
  logic [2:0]  prio_q [SLOTS];
  logic [31:0] seq_ctr;
  dispatch_result_t pending[$];
  int errors;

  function new();
    foreach (used[i]) used[i] = 0;
    seq_ctr = 0;
    errors = 0;
  endfunction

  function void note_input(logic op, logic [15:0] h, logic [28:0] d, logic [2:0] p,
                           logic [31:0] now);
    dispatch_result_t r;
    logic [31:0] snap, best, d32;
    int sel, cnt;
    r.acc = 0; r.handle = 0; r.last = 1;
    if (op == dpdt_pkg::OP_ADD) begin
      r.kind = dpdt_pkg::KIND_ADD;
      if (h != 0 && p >= dpdt_pkg::PRIO_LOW && p <= dpdt_pkg::PRIO_HIGH) begin
        for (int i = 0; i < SLOTS; i++) begin
          if (!used[i]) begin
            d32 = {3'b0, d};
            used[i] = 1; handle_q[i] = h; start_q[i] = now;
            delay_q[i] = d32 * 32'd10; seq_q[i] = seq_ctr; prio_q[i] = p;
            seq_ctr = seq_ctr + 1;
            r.acc = 1;
            break;
          end
        end
      end
      pending.push_back(r);
      return;
    end
    snap = seq_ctr;
    cnt = 0;
    for (int pr = dpdt_pkg::PRIO_HIGH; pr >= dpdt_pkg::PRIO_LOW && cnt < LIMIT; pr--) begin
      while (cnt < LIMIT) begin
        sel = -1; best = snap;
        for (int i = 0; i < SLOTS; i++)
          if (used[i] && prio_q[i] == pr && seq_q[i] < snap &&
              (now - start_q[i]) >= delay_q[i] && seq_q[i] < best) begin
            sel = i; best = seq_q[i];
          end
        if (sel < 0) break;
        used[sel] = 0;
        r.kind = dpdt_pkg::KIND_DISPATCH; r.handle = handle_q[sel]; r.last = 0;
        pending.push_back(r);
        cnt++;
      end
    end
    if (cnt == 0) begin
      r.kind = dpdt_pkg::KIND_EMPTY; r.handle = 0; r.last = 1;
      pending.push_back(r);
    end else begin
      pending[pending.size() - 1].last = 1;
    end
  endfunction

  function void check_result(logic [1:0] k, logic a, logic [15:0] h, logic l);
    dispatch_result_t e;
    if (pending.size() == 0) begin
      $display("%0t: unexpected result kind=%0d acc=%0d handle=%0h last=%0d",
               $time, k, a, h, l);
      errors++;
      return;
    end
    e = pending.pop_front();
    if (k !== e.kind || a !== e.acc || h !== e.handle || l !== e.last) begin
      $display({"%0t: mismatch expected kind=%0d acc=%0d handle=%0h last=%0d, ",
                "actual kind=%0d acc=%0d handle=%0h last=%0d"},
               $time, e.kind, e.acc, e.handle, e.last, k, a, h, l);
      errors++;
    end
  endfunction
endclass

module testbench;
  import dpdt_pkg::*;

  logic        clk_i = 0;
  logic        rst_ni = 0;
  logic        start = 0;
  logic        busy;
  logic        operation_i = 0;
  logic [15:0] task_handle_i = 0;
  logic [28:0] delay_ms_i = 0;
  logic [2:0]  task_priority_i = 0;
  logic [31:0] current_tick_i = 0;
  logic        result_strobe_o;
  logic [1:0]  result_kind_o;
  logic        accepted_o;
  logic [15:0] dispatched_handle_o;
  logic        last_o;

  dispatch_scoreboard sb = new();
  logic [31:0] tick_now = 0;
  bit quiet = 0;

  always #2 clk_i = ~clk_i;

  delayed_priority_dispatch_table uut (.*);

  always @(posedge clk_i) begin
    if (rst_ni && result_strobe_o)
      sb.check_result(result_kind_o, accepted_o, dispatched_handle_o, last_o);
  end

  // Presents one item and holds it until the transfer happens. start stays high
  // afterwards, so a following item goes out at once unless a gap lowers it.
  task automatic send_item(logic op, logic [15:0] h, logic [28:0] d, logic [2:0] p,
                           logic [31:0] now);
    int gap;
    if (!quiet && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 19);
      start <= 0;
      repeat (gap) @(negedge clk_i);
    end
    start <= 1; operation_i <= op; task_handle_i <= h; delay_ms_i <= d;
    task_priority_i <= p; current_tick_i <= now;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    sb.note_input(op, h, d, p, now);
    @(negedge clk_i);
  endtask

  task automatic add_task(logic [15:0] h, logic [28:0] d, logic [2:0] p);
    send_item(OP_ADD, h, d, p, tick_now);
  endtask

  task automatic update_at(logic [31:0] now);
    send_item(OP_UPDATE, 16'($urandom), 29'($urandom), 3'($urandom), now);
  endtask

  task automatic drain();
    int guard;
    guard = 0;
    start <= 0;
    while (sb.pending.size() != 0 && guard < 10000) begin
      @(negedge clk_i);
      guard++;
    end
    repeat (50) @(negedge clk_i);
  endtask

  initial begin
    #2000000;
    $display("FAILED: results differ");
    $finish;
  end

  initial begin
    int r;
    logic [15:0] h;
    repeat (10) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Directed: rejects, extremes, full table, limit, wrap of tick.
    add_task(16'h0000, 29'd5, 3'd2);
    add_task(16'h1234, 29'd5, 3'd0);
    add_task(16'h1234, 29'd5, 3'd5);
    add_task(16'h1234, 29'd5, 3'd7);
    update_at(32'd0);
    tick_now = 32'hFFFF_FFF0;
    add_task(16'hFFFF, 29'd0, 3'd4);
    add_task(16'h0001, 29'h1FFF_FFFF, 3'd1);
    add_task(16'hA5A5, 29'd1, 3'd1);
    add_task(16'h5A5A, 29'd1, 3'd4);
    add_task(16'h0F0F, 29'd0, 3'd2);
    add_task(16'hF0F0, 29'd0, 3'd3);
    add_task(16'h1111, 29'd0, 3'd3);
    add_task(16'h2222, 29'd0, 3'd2);
    add_task(16'h3333, 29'd0, 3'd2);
    update_at(32'd20);
    update_at(32'd20);
    update_at(32'd20);
    update_at(32'hFFFF_FFFF);
    // Sender waits for everything outstanding.
    drain();

    for (int n = 0; n < 450; n++) begin
      if (n > 400) quiet = 1;
      tick_now = tick_now + $urandom_range(0, 40);
      r = $urandom_range(0, 99);
      h = 16'($urandom);
      if (r < 55) begin
        if ($urandom_range(0, 9) == 0) h = 0;
        send_item(OP_ADD, h,
                  ($urandom_range(0, 15) == 0) ? 29'($urandom) : 29'($urandom_range(0, 4)),
                  ($urandom_range(0, 7) == 0) ? 3'($urandom) : 3'($urandom_range(1, 4)),
                  tick_now);
      end else if (r < 97) begin
        update_at(tick_now);
      end else begin
        send_item(OP_UPDATE, h, 29'($urandom), 3'($urandom), $urandom);
      end
    end
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("PASSED: all results match");
    else
      $display("FAILED: results differ");
    $finish;
  end
endmodule
